// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== rtl/usvg_pkg.sv =====
// Shared constants, types and helper functions of the UV sphere vertex pipeline.
package usvg_pkg;

  localparam int MAX_COUNT     = 1024;
  localparam int CNT_W         = 11;
  localparam int RADIUS_W      = 16;
  localparam int TEX_W         = 17;
  localparam int POS_W         = 17;
  localparam int NRM_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STACKS  = 2'd2;

  // long division: numerator is index * 2^16 + count / 2
  localparam int DIV_STEPS = TEX_W;
  localparam int NUM_W     = CNT_W + 16;
  localparam int REM_W     = NUM_W - DIV_STEPS;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                : ATAN_ENTRIES;
  localparam int CW     = 34;  // CORDIC datapath, Q4.30
  localparam int TRIG_W = 32;  // Q2.30 trig values
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

  localparam int POS_LIM = 65535;
  localparam int NRM_LIM = 16384;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_lat;
    logic signed [TRIG_W-1:0] sin_lat;
    logic signed [TRIG_W-1:0] cos_lon;
    logic signed [TRIG_W-1:0] sin_lon;
    logic [TEX_W-1:0]         tex_s;
    logic [TEX_W-1:0]         tex_t;
  } trig_t;

  typedef struct packed {
    logic [TEX_W-1:0]        tex_t;
    logic [TEX_W-1:0]        tex_s;
    logic signed [NRM_W-1:0] z_normal;
    logic signed [NRM_W-1:0] y_normal;
    logic signed [NRM_W-1:0] x_normal;
    logic signed [POS_W-1:0] z_pos;
    logic signed [POS_W-1:0] y_pos;
    logic signed [POS_W-1:0] x_pos;
  } vertex_t;

  // atan(2^-i) as a fraction of a full turn scaled by 2^32
  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  // zero acts as one, large counts are capped
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > CNT_W'(MAX_COUNT)) begin
      r = CNT_W'(MAX_COUNT);
    end else begin
      r = c;
    end
    return r;
  endfunction

  // add half, floor shift, saturate to +-lim
  function automatic logic signed [63:0] rnd_sat(input logic signed [63:0] v,
                                                 input int sh,
                                                 input logic signed [63:0] lim);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

// ===== rtl/uv_sphere_vertex_generator.sv =====
// Top level of the UV sphere vertex pipeline.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+--------------------------------------------
//  s_      | in  | s_tvalid/tready  | tdata: stack_index, sector_index
//  m_      | out | m_tvalid/tready  | tdata: x,y,z_pos, x,y,z_normal, tex_s, tex_t
//  cfg_    | in  | cfg_we           | cfg_index, cfg_data
//
// One request per cycle unless the output stalls. Path: divider input register, 17
// divider steps, angle fold (combinational), CORDIC input register, 16 CORDIC steps, 4
// multiply stages. Divider and CORDIC retire one bit or rotation per stage, setting the depth.
// Reset clears the valid bits and loads radius 1.0, 36 sectors, 18 stacks.
// The whole pipe moves as one: it halts only when the output holds a vertex
// that is not taken, so nothing is dropped or repeated across a stall.
module uv_sphere_vertex_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [10:0] stack_index, [21:11] sector_index
  input  logic [23:0]                     s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [16:0] x_pos, [33:17] y_pos, [50:34] z_pos, [66:51] x_normal,
  // [82:67] y_normal, [98:83] z_normal, [115:99] tex_s, [132:116] tex_t
  output logic [135:0]                    m_tdata,
  input  logic                            cfg_we,
  input  logic [usvg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [usvg_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  localparam int CW = usvg_pkg::CNT_W;

  logic [usvg_pkg::RADIUS_W-1:0] sphere_radius;
  logic [CW-1:0]                 sector_count;
  logic [CW-1:0]                 stack_count;
  logic [CW-1:0]                 sector_eff, stack_eff;

  logic                          adv;
  logic                          div_valid, cor_valid;
  logic [usvg_pkg::TEX_W-1:0]    div_s, div_t;
  usvg_pkg::trig_t               trig;
  usvg_pkg::vertex_t             vtx;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 16'd256;
      sector_count  <= 11'd36;
      stack_count   <= 11'd18;
    end else if (cfg_we) begin
      unique case (cfg_index)
        usvg_pkg::CFG_RADIUS:  sphere_radius <= cfg_data;
        usvg_pkg::CFG_SECTORS: sector_count  <= cfg_data[CW-1:0];
        usvg_pkg::CFG_STACKS:  stack_count   <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  assign sector_eff = usvg_pkg::eff_count(sector_count);
  assign stack_eff  = usvg_pkg::eff_count(stack_count);

  // global advance: move unless the output register is blocked
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  usvg_div u_div (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (s_tvalid),
    .stack_index  (s_tdata[10:0]),
    .sector_index (s_tdata[21:11]),
    .stack_cnt    (stack_eff),
    .sector_cnt   (sector_eff),
    .out_valid    (div_valid),
    .tex_s        (div_s),
    .tex_t        (div_t)
  );

  usvg_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_valid),
    .tex_s     (div_s),
    .tex_t     (div_t),
    .out_valid (cor_valid),
    .trig      (trig)
  );

  usvg_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (cor_valid),
    .trig      (trig),
    .radius    (sphere_radius),
    .out_valid (m_tvalid),
    .vtx       (vtx)
  );

  assign m_tdata = {3'b0, vtx};

  // texture coordinates never pass 1.0
  `ASSERT_IMPL(a_tex_range, clk, rst, m_tvalid, (vtx.tex_s <= 17'd65536) && (vtx.tex_t <= 17'd65536))
  // x and z normals stay inside the saturation bound
  `ASSERT_IMPL(a_nrm_range, clk, rst, m_tvalid, (vtx.x_normal <= 16'sd16384) && (vtx.x_normal >= -16'sd16384) && (vtx.z_normal <= 16'sd16384) && (vtx.z_normal >= -16'sd16384))
  // a blocked output with no config write holds the output vertex and the divider result
  `ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready && !cfg_we, $stable(vtx) && $stable(div_s))

endmodule

// ===== rtl/usvg_div.sv =====
// Pipelined restoring divider producing the s and t texture coordinates.
module usvg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [usvg_pkg::CNT_W-1:0]    stack_index,
  input  logic [usvg_pkg::CNT_W-1:0]    sector_index,
  input  logic [usvg_pkg::CNT_W-1:0]    stack_cnt,
  input  logic [usvg_pkg::CNT_W-1:0]    sector_cnt,
  output logic                          out_valid,
  output logic [usvg_pkg::TEX_W-1:0]    tex_s,
  output logic [usvg_pkg::TEX_W-1:0]    tex_t
);

  localparam int N = usvg_pkg::DIV_STEPS;
  localparam int RW = usvg_pkg::REM_W;
  localparam int QW = usvg_pkg::TEX_W;
  localparam int NW = usvg_pkg::NUM_W;
  localparam int CW = usvg_pkg::CNT_W;

  logic          valid [N+1];
  logic [RW-1:0] rem_s [N+1];
  logic [RW-1:0] rem_t [N+1];
  logic [QW-1:0] q_s   [N+1];
  logic [QW-1:0] q_t   [N+1];

  logic [CW-1:0] se_c, st_c;
  logic [NW-1:0] num_s, num_t;

  always_comb begin
    se_c  = (sector_index > sector_cnt) ? sector_cnt : sector_index;
    st_c  = (stack_index > stack_cnt) ? stack_cnt : stack_index;
    num_s = {se_c, 16'b0} + NW'(sector_cnt >> 1);
    num_t = {st_c, 16'b0} + NW'(stack_cnt >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (adv) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_s[0] <= num_s[NW-1:QW];
      q_s[0]   <= num_s[QW-1:0];
      rem_t[0] <= num_t[NW-1:QW];
      q_t[0]   <= num_t[QW-1:0];
    end
  end

  // one quotient bit per stage; numerator bits shift out as quotient bits shift in
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RW:0] tmp_s, tmp_t;
    logic        ge_s, ge_t;

    always_comb begin
      tmp_s = {rem_s[k], q_s[k][QW-1]};
      tmp_t = {rem_t[k], q_t[k][QW-1]};
      ge_s  = tmp_s >= (RW+1)'(sector_cnt);
      ge_t  = tmp_t >= (RW+1)'(stack_cnt);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (adv) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_s[k+1] <= ge_s ? RW'(tmp_s - (RW+1)'(sector_cnt)) : tmp_s[RW-1:0];
        rem_t[k+1] <= ge_t ? RW'(tmp_t - (RW+1)'(stack_cnt)) : tmp_t[RW-1:0];
        q_s[k+1]   <= {q_s[k][QW-2:0], ge_s};
        q_t[k+1]   <= {q_t[k][QW-2:0], ge_t};
      end
    end
  end

  assign out_valid = valid[N];
  assign tex_s     = q_s[N];
  assign tex_t     = q_t[N];

endmodule

// ===== rtl/usvg_cordic.sv =====
// Dual pipelined rotation CORDIC for latitude and longitude sine and cosine.
module usvg_cordic (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [usvg_pkg::TEX_W-1:0] tex_s,
  input  logic [usvg_pkg::TEX_W-1:0] tex_t,
  output logic                       out_valid,
  output usvg_pkg::trig_t            trig
);

  localparam int N  = usvg_pkg::CORDIC_N;
  localparam int CW = usvg_pkg::CW;
  localparam int TW = usvg_pkg::TRIG_W;
  localparam int QW = usvg_pkg::TEX_W;

  logic                 valid [N+1];
  logic signed [CW-1:0] xl [N+1];
  logic signed [CW-1:0] yl [N+1];
  logic signed [CW-1:0] zl [N+1];
  logic signed [CW-1:0] xo [N+1];
  logic signed [CW-1:0] yo [N+1];
  logic signed [CW-1:0] zo [N+1];
  logic                 fl [N+1];
  logic                 fo [N+1];
  logic [QW-1:0]        ss [N+1];
  logic [QW-1:0]        ts [N+1];

  // binary angles: a full turn is 2^32
  logic [31:0]          lon, lat;
  logic signed [CW-1:0] zl0, zo0;
  logic                 fl0, fo0;

  always_comb begin
    lon = {tex_s[15:0], 16'b0};
    lat = 32'h40000000 - {tex_t, 15'b0};
    zl0 = CW'($signed(lat));
    zo0 = CW'($signed(lon));
    fl0 = 1'b0;
    fo0 = 1'b0;
    // fold into the right half plane; results get negated at the end
    if (zl0 > 34'sh040000000) begin
      zl0 = zl0 - 34'sh080000000;
      fl0 = 1'b1;
    end else if (zl0 < -34'sh040000000) begin
      zl0 = zl0 + 34'sh080000000;
      fl0 = 1'b1;
    end
    if (zo0 > 34'sh040000000) begin
      zo0 = zo0 - 34'sh080000000;
      fo0 = 1'b1;
    end else if (zo0 < -34'sh040000000) begin
      zo0 = zo0 + 34'sh080000000;
      fo0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (adv) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xl[0] <= usvg_pkg::CORDIC_GAIN;
      yl[0] <= '0;
      zl[0] <= zl0;
      fl[0] <= fl0;
      xo[0] <= usvg_pkg::CORDIC_GAIN;
      yo[0] <= '0;
      zo[0] <= zo0;
      fo[0] <= fo0;
      ss[0] <= tex_s;
      ts[0] <= tex_t;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [CW-1:0] ATAN = CW'(usvg_pkg::atan_val(k));

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (adv) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (zl[k] >= 0) begin
          xl[k+1] <= xl[k] - (yl[k] >>> k);
          yl[k+1] <= yl[k] + (xl[k] >>> k);
          zl[k+1] <= zl[k] - ATAN;
        end else begin
          xl[k+1] <= xl[k] + (yl[k] >>> k);
          yl[k+1] <= yl[k] - (xl[k] >>> k);
          zl[k+1] <= zl[k] + ATAN;
        end
        if (zo[k] >= 0) begin
          xo[k+1] <= xo[k] - (yo[k] >>> k);
          yo[k+1] <= yo[k] + (xo[k] >>> k);
          zo[k+1] <= zo[k] - ATAN;
        end else begin
          xo[k+1] <= xo[k] + (yo[k] >>> k);
          yo[k+1] <= yo[k] - (xo[k] >>> k);
          zo[k+1] <= zo[k] + ATAN;
        end
        fl[k+1] <= fl[k];
        fo[k+1] <= fo[k];
        ss[k+1] <= ss[k];
        ts[k+1] <= ts[k];
      end
    end
  end

  always_comb begin
    trig.cos_lat = TW'(fl[N] ? -xl[N] : xl[N]);
    trig.sin_lat = TW'(fl[N] ? -yl[N] : yl[N]);
    trig.cos_lon = TW'(fo[N] ? -xo[N] : xo[N]);
    trig.sin_lon = TW'(fo[N] ? -yo[N] : yo[N]);
    trig.tex_s   = ss[N];
    trig.tex_t   = ts[N];
  end

  assign out_valid = valid[N];

endmodule

// ===== rtl/usvg_mult.sv =====
// Product, rounding and saturation stages for normal and position.
module usvg_mult (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  usvg_pkg::trig_t               trig,
  input  logic [usvg_pkg::RADIUS_W-1:0] radius,
  output logic                          out_valid,
  output usvg_pkg::vertex_t             vtx
);

  localparam int TW = usvg_pkg::TRIG_W;
  localparam int RP = usvg_pkg::RADIUS_W + 1 + TW;

  localparam logic signed [63:0] PLIM = 64'(usvg_pkg::POS_LIM);
  localparam logic signed [63:0] NLIM = 64'(usvg_pkg::NRM_LIM);

  logic                         v1, v2, v3, v4;
  logic signed [2*TW-1:0]       p_co, p_so;
  logic signed [TW-1:0]         sl1, sl2;
  logic signed [TW-1:0]         px2, py2;
  logic [usvg_pkg::TEX_W-1:0]   s1, t1, s2, t2, s3, t3;
  logic signed [usvg_pkg::NRM_W-1:0] xn2, yn2, zn2, xn3, yn3, zn3;
  logic signed [RP-1:0]         rx3, ry3;
  logic signed [RP-1:0]         rz3;
  logic signed [usvg_pkg::RADIUS_W:0] r_s;
  logic signed [63:0]           px_w, py_w;

  assign r_s = {1'b0, radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_comb begin
    px_w = usvg_pkg::rnd_sat(64'(p_co), 30, 64'sh3FFFFFFFFFFFFFFF);
    py_w = usvg_pkg::rnd_sat(64'(p_so), 30, 64'sh3FFFFFFFFFFFFFFF);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // unit products
      p_co <= trig.cos_lat * trig.cos_lon;
      p_so <= trig.cos_lat * trig.sin_lon;
      sl1  <= trig.sin_lat;
      s1   <= trig.tex_s;
      t1   <= trig.tex_t;
      // normals and rounded unit position
      px2  <= TW'(px_w);
      py2  <= TW'(py_w);
      xn2  <= 16'(usvg_pkg::rnd_sat(64'(p_co), 46, NLIM));
      yn2  <= 16'(usvg_pkg::rnd_sat(64'(p_so), 46, NLIM));
      zn2  <= 16'(usvg_pkg::rnd_sat(64'(sl1), 16, NLIM));
      sl2  <= sl1;
      s2   <= s1;
      t2   <= t1;
      // radius scaling
      rx3  <= r_s * px2;
      ry3  <= r_s * py2;
      rz3  <= r_s * sl2;
      xn3  <= xn2;
      yn3  <= yn2;
      zn3  <= zn2;
      s3   <= s2;
      t3   <= t2;
      // output register
      vtx.x_pos    <= 17'(usvg_pkg::rnd_sat(64'(rx3), 30, PLIM));
      vtx.y_pos    <= 17'(usvg_pkg::rnd_sat(64'(ry3), 30, PLIM));
      vtx.z_pos    <= 17'(usvg_pkg::rnd_sat(64'(rz3), 30, PLIM));
      vtx.x_normal <= xn3;
      vtx.y_normal <= yn3;
      vtx.z_normal <= zn3;
      vtx.tex_s    <= s3;
      vtx.tex_t    <= t3;
    end
  end

  assign out_valid = v4;

endmodule
